FILE: hdl/assert_macros.svh
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, sampled on clk, off while rst is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check, sampled on clk, also during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/ppdb_pkg.sv
`default_nettype none
package ppdb_pkg;

  localparam int DEF_IMG_WIDTH  = 710;
  localparam int DEF_IMG_HEIGHT = 540;
  localparam int COORD_FRAC     = 14;
  localparam int FOCAL_FRAC     = 8;

  localparam int OP_W     = 2;
  localparam int COORD_W  = 16;
  localparam int PIXC_W   = 10;
  localparam int DEPTH_W  = 16;
  localparam int STAT_W   = 3;
  localparam int FOCAL_W  = 20;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  localparam int PROD_W = COORD_W + FOCAL_W + 1;
  localparam int QUO_W  = PROD_W - 1 - FOCAL_FRAC;
  localparam int Z_W    = 18;
  localparam int ZDIV_W = Z_W - 1;
  localparam int POS_W  = QUO_W + 2;
  localparam int CNT_W  = $clog2(QUO_W + 1);

  localparam logic [DEPTH_W-1:0] FAR_DEPTH =
    (COORD_FRAC >= DEPTH_W) ? {DEPTH_W{1'b1}} : DEPTH_W'(1 << COORD_FRAC);

  localparam logic [OP_W-1:0] OP_PROJECT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

  localparam logic [STAT_W-1:0] ST_WRITTEN    = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_NEARER = 3'd1;
  localparam logic [STAT_W-1:0] ST_OUTSIDE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONPOS     = 3'd3;
  localparam logic [STAT_W-1:0] ST_READ       = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLEARED    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CCOL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CROW   = 2'd3;

  typedef enum logic [1:0] {
    RES_NONPOS  = 2'd0,
    RES_OUTSIDE = 2'd1,
    RES_MEM     = 2'd2,
    RES_CLEAR   = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     prep;
    logic     div_step;
    logic     div_next;
    logic     pos;
    logic     rd_issue;
    logic     res_load;
    res_sel_t res_sel;
    logic     wr_upd;
    logic     out_load;
    logic     clr_start;
    logic     clr_step;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            z_pos;
    logic            div_done;
    logic            inframe;
    logic            clr_last;
  } stat_t;

endpackage
`default_nettype wire

FILE: hdl/ppdb_ram.sv
`default_nettype none
module ppdb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic      [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      q <= mem[ra];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ppdb_dp.sv
`default_nettype none
module ppdb_dp import ppdb_pkg::*; #(
  parameter int IMG_WIDTH  = DEF_IMG_WIDTH,
  parameter int IMG_HEIGHT = DEF_IMG_HEIGHT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  output stat_t                       st,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [FOCAL_W-1:0]     cfg_data,
  input  wire logic [IN_TDATA_W-1:0]  in_data,
  input  wire logic [OP_W-1:0]        in_op,
  output logic      [DEPTH_W-1:0]     out_depth,
  output logic      [PIXC_W-1:0]      out_row,
  output logic      [PIXC_W-1:0]      out_col,
  output logic      [STAT_W-1:0]      out_status
);

  localparam int PIX = IMG_WIDTH * IMG_HEIGHT;
  localparam int AW  = $clog2(PIX);
  localparam int RB  = $clog2(IMG_HEIGHT);
  localparam int CB  = $clog2(IMG_WIDTH);

  logic [FOCAL_W-1:0] focal;
  logic [DEPTH_W-1:0] offset;
  logic [PIXC_W-1:0]  ccol;
  logic [PIXC_W-1:0]  crow;

  logic [OP_W-1:0]           op_r;
  logic signed [COORD_W-1:0] a_r;
  logic signed [COORD_W-1:0] b_r;
  logic signed [COORD_W-1:0] c_r;

  logic signed [Z_W-1:0]     z;
  logic signed [FOCAL_W:0]   f_s;
  logic signed [PROD_W-1:0]  prod_c;
  logic signed [PROD_W-1:0]  prod_a;
  logic [PROD_W-1:0]         abs_c;
  logic [PROD_W-1:0]         abs_a;

  logic [QUO_W-1:0]   num;
  logic [QUO_W-1:0]   na;
  logic [QUO_W-1:0]   qc;
  logic [ZDIV_W-1:0]  rem;
  logic [ZDIV_W-1:0]  zdiv;
  logic [CNT_W-1:0]   cnt;
  logic [ZDIV_W:0]    rem_sh;
  logic               neg_c;
  logic               neg_a;
  logic [DEPTH_W-1:0] zs_r;

  logic [POS_W-1:0] qcs;
  logic [POS_W-1:0] qas;
  logic [POS_W-1:0] row_r;
  logic [POS_W-1:0] col_r;
  logic             inframe;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    idx_r;
  logic             ok_r;

  logic [AW-1:0]      clr_addr;
  logic               ram_we;
  logic [AW-1:0]      ram_wa;
  logic [DEPTH_W-1:0] ram_wd;
  logic [DEPTH_W-1:0] q;
  logic               nearer;

  logic [DEPTH_W-1:0] res_depth;
  logic [PIXC_W-1:0]  res_row;
  logic [PIXC_W-1:0]  res_col;
  logic [STAT_W-1:0]  res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal  <= FOCAL_W'(252444);
      offset <= DEPTH_W'(12288);
      ccol   <= PIXC_W'(355);
      crow   <= PIXC_W'(270);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOCAL:  focal  <= cfg_data;
        CFG_OFFSET: offset <= cfg_data[DEPTH_W-1:0];
        CFG_CCOL:   ccol   <= cfg_data[PIXC_W-1:0];
        CFG_CROW:   crow   <= cfg_data[PIXC_W-1:0];
        default:    ;
      endcase
    end
  end

  assign z      = $signed({2'b00, offset}) - $signed({{(Z_W-COORD_W){b_r[COORD_W-1]}}, b_r});
  assign f_s    = $signed({1'b0, focal});
  assign prod_c = PROD_W'(c_r) * PROD_W'(f_s);
  assign prod_a = PROD_W'(a_r) * PROD_W'(f_s);
  assign abs_c  = prod_c[PROD_W-1] ? PROD_W'(-prod_c) : PROD_W'(prod_c);
  assign abs_a  = prod_a[PROD_W-1] ? PROD_W'(-prod_a) : PROD_W'(prod_a);
  assign rem_sh = {rem, num[QUO_W-1]};

  assign qcs = neg_c ? POS_W'(-{2'b00, qc})  : {2'b00, qc};
  assign qas = neg_a ? POS_W'(-{2'b00, num}) : {2'b00, num};

  assign inframe = !row_r[POS_W-1] && (row_r < POS_W'(IMG_HEIGHT)) &&
                   !col_r[POS_W-1] && (col_r < POS_W'(IMG_WIDTH));
  assign rd_addr = AW'(row_r[RB-1:0]) * AW'(IMG_WIDTH) + AW'(col_r[CB-1:0]);
  assign nearer  = q > zs_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_op;
      a_r   <= in_data[15:0];
      b_r   <= in_data[31:16];
      c_r   <= in_data[47:32];
      row_r <= POS_W'(in_data[57:48]);
      col_r <= POS_W'(in_data[67:58]);
    end
    if (cmd.prep) begin
      num   <= abs_c[PROD_W-2:FOCAL_FRAC];
      na    <= abs_a[PROD_W-2:FOCAL_FRAC];
      neg_c <= prod_c[PROD_W-1];
      neg_a <= prod_a[PROD_W-1];
      zdiv  <= z[ZDIV_W-1:0];
      rem   <= '0;
      cnt   <= CNT_W'(QUO_W);
      zs_r  <= (z[Z_W-1:DEPTH_W] != '0) ? {DEPTH_W{1'b1}} : z[DEPTH_W-1:0];
    end else if (cmd.div_next) begin
      qc  <= num;
      num <= na;
      rem <= '0;
      cnt <= CNT_W'(QUO_W);
    end else if (cmd.div_step && cnt != '0) begin
      cnt <= cnt - 1'b1;
      if (rem_sh >= {1'b0, zdiv}) begin
        rem <= ZDIV_W'(rem_sh - {1'b0, zdiv});
        num <= {num[QUO_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[ZDIV_W-1:0];
        num <= {num[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd.pos) begin
      col_r <= qcs + POS_W'(ccol);
      row_r <= POS_W'(crow) - qas;
    end
    if (cmd.rd_issue) begin
      idx_r <= rd_addr;
      ok_r  <= inframe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= (clr_addr == AW'(PIX - 1)) ? '0 : clr_addr + 1'b1;
    end
  end

  assign ram_we = cmd.clr_step || (cmd.wr_upd && op_r == OP_PROJECT && nearer);
  assign ram_wa = cmd.clr_step ? clr_addr : idx_r;
  assign ram_wd = cmd.clr_step ? FAR_DEPTH : zs_r;

  ppdb_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (PIX)
  ) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (cmd.rd_issue && inframe),
    .ra  (rd_addr),
    .q   (q)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_NONPOS: begin
          res_depth  <= '0;
          res_row    <= '0;
          res_col    <= '0;
          res_status <= ST_NONPOS;
        end
        RES_OUTSIDE: begin
          res_depth  <= '0;
          res_row    <= '0;
          res_col    <= '0;
          res_status <= ST_OUTSIDE;
        end
        RES_CLEAR: begin
          res_depth  <= FAR_DEPTH;
          res_row    <= '0;
          res_col    <= '0;
          res_status <= ST_CLEARED;
        end
        default: begin
          res_row <= row_r[PIXC_W-1:0];
          res_col <= col_r[PIXC_W-1:0];
          if (op_r == OP_PROJECT) begin
            res_depth  <= nearer ? zs_r : q;
            res_status <= nearer ? ST_WRITTEN : ST_NOT_NEARER;
          end else begin
            res_depth  <= ok_r ? q : '0;
            res_status <= ST_READ;
          end
        end
      endcase
    end
    if (cmd.out_load) begin
      out_depth  <= res_depth;
      out_row    <= res_row;
      out_col    <= res_col;
      out_status <= res_status;
    end
  end

  assign st.op       = op_r;
  assign st.z_pos    = !z[Z_W-1] && (z != '0);
  assign st.div_done = (cnt == '0);
  assign st.inframe  = inframe;
  assign st.clr_last = (clr_addr == AW'(PIX - 1));

endmodule
`default_nettype wire

FILE: hdl/ppdb_ctrl.sv
`default_nettype none
module ppdb_ctrl import ppdb_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [OP_W-1:0] s_op,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  input  wire stat_t           st,
  output cmd_t                 cmd
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_DIVC  = 8'b0000_1000,
    S_DIVA  = 8'b0001_0000,
    S_ADDR  = 8'b0010_0000,
    S_RD    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   report;
  logic   report_next;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next  = state;
    report_next = report;
    cmd         = '0;
    cmd.res_sel = RES_MEM;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          if (report) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_CLEAR;
            state_next   = S_DONE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          case (s_op)
            OP_PROJECT: state_next = S_PREP;
            OP_READ:    state_next = S_ADDR;
            OP_CLEAR: begin
              cmd.clr_start = 1'b1;
              report_next   = 1'b1;
              state_next    = S_CLEAR;
            end
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_PREP: begin
        if (st.z_pos) begin
          cmd.prep   = 1'b1;
          state_next = S_DIVC;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_NONPOS;
          state_next   = S_DONE;
        end
      end
      S_DIVC: begin
        if (st.div_done) begin
          cmd.div_next = 1'b1;
          state_next   = S_DIVA;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DIVA: begin
        if (st.div_done) begin
          cmd.pos    = 1'b1;
          state_next = S_ADDR;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_ADDR: begin
        if (st.op == OP_PROJECT && !st.inframe) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_OUTSIDE;
          state_next   = S_DONE;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_RD;
        end
      end
      S_RD: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_MEM;
        cmd.wr_upd   = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          report_next  = 1'b0;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      report   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      report <= report_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/point_projection_depth_buffer.sv
// Channel | Direction | Handshake         | Contents
// s       | in        | s_tvalid/s_tready | tuser opcode, tdata point or pixel request
// m       | out       | m_tvalid/m_tready | tuser status, tdata depth, row, column
// cfg     | in        | cfg_valid/cfg_ready | register index and write data
//
// A point goes from its transfer through setup, two divider passes (one quotient bit per
// cycle, column then row), address, store update and output. A nonpositive depth goes from
// setup to output, a point outside the frame from address to output; a pixel read skips
// setup and divider; opcode 3 returns to idle. A clear sweeps one pixel per cycle over
// all IMG_WIDTH*IMG_HEIGHT pixels; after reset such a sweep runs before s_tready rises.
// A held result stalls the next one in its last step; cfg writes are taken throughout.
`default_nettype none
module point_projection_depth_buffer import ppdb_pkg::*; #(
  parameter int IMG_WIDTH  = DEF_IMG_WIDTH,
  parameter int IMG_HEIGHT = DEF_IMG_HEIGHT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // pt_a, pt_b, pt_c, read_row, read_col, zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // opcode
  input  wire logic [OP_W-1:0]        s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // depth_value, pixel_row, pixel_col, zero fill
  output logic      [OUT_TDATA_W-1:0] m_tdata,
  // status
  output logic      [STAT_W-1:0]      m_tuser,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [FOCAL_W-1:0]     cfg_data
);

  cmd_t               cmd;
  stat_t              st;
  logic [DEPTH_W-1:0] out_depth;
  logic [PIXC_W-1:0]  out_row;
  logic [PIXC_W-1:0]  out_col;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(OUT_TDATA_W - DEPTH_W - 2*PIXC_W){1'b0}}, out_col, out_row, out_depth};

  ppdb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_op     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ppdb_dp #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_data    (s_tdata),
    .in_op      (s_tuser),
    .out_depth  (out_depth),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_status (m_tuser)
  );

endmodule
`default_nettype wire

FILE: hdl/ppdb_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ppdb_checker import ppdb_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic [OP_W-1:0]        s_tuser,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic [STAT_W-1:0]      m_tuser
);

  `ASSERT_CLK(a_busy_after_take, s_tvalid && s_tready && s_tuser != OP_NONE |=> !s_tready, "input taken while busy")
  `ASSERT_CLK(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `ASSERT_CLK(a_status_range, m_tvalid |-> m_tuser <= ST_CLEARED, "unknown status code")
  `ASSERT_CLK(a_reject_zero, m_tvalid && (m_tuser == ST_OUTSIDE || m_tuser == ST_NONPOS) |-> m_tdata[35:0] == '0, "rejected point carries data")

endmodule

bind point_projection_depth_buffer ppdb_checker u_ppdb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
